>>> hw/rtl/tmtw_pkg.sv
package tmtw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_TOTAL = COLUMNS * ROWS;
    localparam int TAB_STEP   = 4;

    // Derived widths.
    localparam int ADDR_W = $clog2(CELL_TOTAL);
    localparam int CNT_W  = $clog2(CELL_TOTAL + 1);
    localparam int CUR_W  = $clog2(CELL_TOTAL + TAB_STEP);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int TAB_W  = $clog2(TAB_STEP + 1);

    // Fixed field widths of the channels.
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int CELL_ADDR_W = 11;
    localparam int POS_W       = 11;
    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 4;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd14;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;
    localparam logic [CELL_W-1:0]  BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } tmtw_cfg_t;

endpackage

>>> hw/rtl/text_mode_terminal_writer.sv
// An item is taken in the idle state, carried out in the execute state and its result
// registered in the response state once the output register is free; the sequencer takes
// no new item until it is back in idle. A scroll copies the rows up through the cell memory,
// then blanks a row; a clear writes one blank per cell, one memory write per cell (2000 at 80 by 25).
// Reset (aresetn low, synchronous) homes the cursor and sets the colors; afterwards a
// clearing pass blanks the memory while s_ready stays low.
module text_mode_terminal_writer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tmtw_pkg::FUNC_W-1:0]           s_func,
    input  logic [tmtw_pkg::CHAR_W-1:0]           s_char_code,
    input  logic [tmtw_pkg::CELL_ADDR_W-1:0]      s_cell_address,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tmtw_pkg::POS_W-1:0]            m_cursor_pos,
    output logic [tmtw_pkg::CELL_W-1:0]           m_cell_data
);
    import tmtw_pkg::*;

    // Register index codes; bit 2 of the byte address selects the register.
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    tmtw_cfg_t         cfg_reg;
    logic              reg_idx;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    // The color registers are written in the access phase of an APB write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg <= FG_RESET;
            cfg_reg.bg <= BG_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FG: cfg_reg.fg <= pwdata[COLOR_W-1:0];
                REG_BG: cfg_reg.bg <= pwdata[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FG:  prdata = 32'(cfg_reg.fg);
            REG_BG:  prdata = 32'(cfg_reg.bg);
            default: prdata = '0;
        endcase
    end

    // The sequencer owns the cursor, the output register and every memory access.
    tmtw_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_char_code    (s_char_code),
        .s_cell_address (s_cell_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_pos   (m_cursor_pos),
        .m_cell_data    (m_cell_data),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // The screen itself: one write port and one registered read port.
    tmtw_cell_ram #(
        .DEPTH (CELL_TOTAL),
        .WIDTH (CELL_W),
        .AW    (ADDR_W)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A reported cursor always lies on the screen, since a scroll follows any overrun.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_pos) < CELL_TOTAL))
        else $error("cursor reported beyond the screen");

    // The block works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while the previous one is still in work");

    // No item is taken during or right after reset, while the clearing pass runs.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during the clearing pass");

endmodule

>>> hw/rtl/tmtw_cell_ram.sv
module tmtw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tmtw_ctrl.sv
module tmtw_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tmtw_pkg::tmtw_cfg_t                   cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tmtw_pkg::FUNC_W-1:0]           s_func,
    input  logic [tmtw_pkg::CHAR_W-1:0]           s_char_code,
    input  logic [tmtw_pkg::CELL_ADDR_W-1:0]      s_cell_address,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tmtw_pkg::POS_W-1:0]            m_cursor_pos,
    output logic [tmtw_pkg::CELL_W-1:0]           m_cell_data,
    output logic                                  mem_we,
    output logic [tmtw_pkg::ADDR_W-1:0]           mem_waddr,
    output logic [tmtw_pkg::CELL_W-1:0]           mem_wdata,
    output logic                                  mem_re,
    output logic [tmtw_pkg::ADDR_W-1:0]           mem_raddr,
    input  logic [tmtw_pkg::CELL_W-1:0]           mem_rdata
);
    import tmtw_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [FUNC_W-1:0]      func_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [CELL_ADDR_W-1:0] addr_reg;
    logic                   rd_sel_reg, rd_sel_next;
    logic                   cp_pend_reg, cp_pend_next;
    logic [ADDR_W-1:0]      cp_addr_reg, cp_addr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [POS_W-1:0]       m_pos_reg;
    logic [CELL_W-1:0]      m_data_reg;
    logic                   out_load;

    // Cursor arithmetic for put.
    logic [CUR_W-1:0] cur_inc, cur_dec, cur_nl, tab_raw, cur_tab, tab_diff, pos_new;
    logic [COL_W-1:0] col_inc, col_dec, col_tab, col_new;
    logic [COL_W:0]   col_sum;
    logic [TAB_W-1:0] tab_delta;
    logic             put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [CHAR_W-1:0] put_char;
    logic [CELL_W-1:0] blank_cell;

    assign blank_cell = {cfg.bg, cfg.fg, CH_SPACE};

    always_comb begin
        cur_inc   = cursor_reg + CUR_W'(1);
        cur_dec   = cursor_reg - CUR_W'(1);
        col_inc   = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
        col_dec   = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
        cur_nl    = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
        tab_raw   = cursor_reg + CUR_W'(TAB_STEP);
        cur_tab   = tab_raw & ~CUR_W'(TAB_STEP - 1);
        tab_diff  = cur_tab - cursor_reg;
        tab_delta = tab_diff[TAB_W-1:0];
        col_sum   = {1'b0, col_reg} + (COL_W+1)'(tab_delta);
        col_tab   = (col_sum >= (COL_W+1)'(COLUMNS))
                  ? COL_W'(col_sum - (COL_W+1)'(COLUMNS)) : col_sum[COL_W-1:0];

        put_we   = 1'b0;
        put_addr = cursor_reg[ADDR_W-1:0];
        put_char = char_reg;
        pos_new  = cursor_reg;
        col_new  = col_reg;
        if (char_reg == CH_NEWLINE) begin
            pos_new = cur_nl;
            col_new = '0;
        end else if (char_reg == CH_BACKSPACE) begin
            if (cursor_reg != '0) begin
                pos_new  = cur_dec;
                col_new  = col_dec;
                put_we   = 1'b1;
                put_addr = cur_dec[ADDR_W-1:0];
                put_char = CH_SPACE;
            end
        end else if (char_reg == CH_TAB) begin
            pos_new = cur_tab;
            col_new = col_tab;
        end else begin
            pos_new = cur_inc;
            col_new = col_inc;
            put_we  = 1'b1;
        end
    end

    assign out_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        rd_sel_next  = rd_sel_reg;
        cp_pend_next = 1'b0;
        cp_addr_next = cp_addr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg[ADDR_W-1:0];
        mem_wdata    = blank_cell;
        mem_re       = 1'b0;
        mem_raddr    = cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_RESET;
                if (cnt_reg == CNT_W'(CELL_TOTAL - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                rd_sel_next = 1'b0;
                state_next  = ST_RESP;
                unique case (func_reg)
                    FUNC_PUT: begin
                        mem_we    = put_we;
                        mem_waddr = put_addr;
                        mem_wdata = {cfg.bg, cfg.fg, put_char};
                        col_next  = col_new;
                        if (pos_new >= CUR_W'(CELL_TOTAL)) begin
                            cursor_next = pos_new - CUR_W'(COLUMNS);
                            cnt_next    = CNT_W'(COLUMNS);
                            state_next  = ST_SCROLL;
                        end else begin
                            cursor_next = pos_new;
                        end
                    end
                    FUNC_CLEAR: begin
                        cursor_next = '0;
                        col_next    = '0;
                        cnt_next    = '0;
                        state_next  = ST_FILL;
                    end
                    FUNC_READ: begin
                        if (32'(addr_reg) < CELL_TOTAL) begin
                            mem_re      = 1'b1;
                            mem_raddr   = ADDR_W'(addr_reg);
                            rd_sel_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCROLL: begin
                // Read one row ahead, write back in the following cycle.
                if (cp_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg != CNT_W'(CELL_TOTAL)) begin
                    mem_re       = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    cp_pend_next = 1'b1;
                    cp_addr_next = ADDR_W'(cnt_reg - CNT_W'(COLUMNS));
                end else begin
                    cnt_next   = CNT_W'(CELL_TOTAL - COLUMNS);
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (cnt_reg == CNT_W'(CELL_TOTAL - 1)) begin
                    state_next = ST_RESP;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            cursor_reg  <= '0;
            col_reg     <= '0;
            rd_sel_reg  <= 1'b0;
            cp_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cursor_reg  <= cursor_next;
            col_reg     <= col_next;
            rd_sel_reg  <= rd_sel_next;
            cp_pend_reg <= cp_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= cp_addr_next;
        if (state_reg == ST_IDLE && s_valid) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
            addr_reg <= s_cell_address;
        end
        if (state_reg == ST_RESP && out_load) begin
            m_pos_reg  <= POS_W'(cursor_reg);
            m_data_reg <= rd_sel_reg ? mem_rdata : '0;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_pos_reg;
    assign m_cell_data  = m_data_reg;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tmtw_pkg::*;

    // The unused operation code: it must leave the screen alone and report the cursor.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Register map of the configuration port, one 32-bit word per register.
    localparam logic [2:0] REG_FG = 3'd0;
    localparam logic [2:0] REG_BG = 3'd4;

    // A scroll or a clear walks the whole screen before its result comes back; after the
    // last result we still let the block sit idle before touching registers.
    localparam int SETTLE_CYCLES = 2 * CELL_TOTAL + 16;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int MAX_GAP       = 18;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_HOLD_AT  = 400;
    localparam int REPORT_CAP    = 200;

    typedef struct {
        logic [FUNC_W-1:0]      func;
        logic [CHAR_W-1:0]      ch;
        logic [CELL_ADDR_W-1:0] addr;
    } term_item_t;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } term_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [FUNC_W-1:0]      s_func = '0;
    logic [CHAR_W-1:0]      s_char_code = '0;
    logic [CELL_ADDR_W-1:0] s_cell_address = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [POS_W-1:0]       m_cursor_pos;
    logic [CELL_W-1:0]      m_cell_data;

    text_mode_terminal_writer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_char_code    (s_char_code),
        .s_cell_address (s_cell_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_pos   (m_cursor_pos),
        .m_cell_data    (m_cell_data)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the terminal: the screen contents, the cursor and the
    // two color registers. Every accepted item is applied here to work out
    // the result the block should report for it.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  shadow_cells [CELL_TOTAL];
    int                 shadow_cursor = 0;
    logic [COLOR_W-1:0] shadow_fg = FG_RESET;
    logic [COLOR_W-1:0] shadow_bg = BG_RESET;

    initial begin
        for (int i = 0; i < CELL_TOTAL; i++) shadow_cells[i] = BLANK_RESET;
    end

    function automatic term_result_t apply_to_screen(term_item_t it);
        term_result_t      r;
        logic [CELL_W-1:0] blank;
        blank  = {shadow_bg, shadow_fg, CH_SPACE};
        r.data = '0;
        case (it.func)
            FUNC_PUT: begin
                if (it.ch == CH_NEWLINE) begin
                    shadow_cursor = shadow_cursor + COLUMNS - shadow_cursor % COLUMNS;
                end else if (it.ch == CH_BACKSPACE) begin
                    // Backspace at the home position is simply ignored.
                    if (shadow_cursor > 0) begin
                        shadow_cursor--;
                        shadow_cells[shadow_cursor] = blank;
                    end
                end else if (it.ch == CH_TAB) begin
                    shadow_cursor = shadow_cursor + TAB_STEP;
                    shadow_cursor = shadow_cursor - shadow_cursor % TAB_STEP;
                end else begin
                    shadow_cells[shadow_cursor] = {shadow_bg, shadow_fg, it.ch};
                    shadow_cursor++;
                end
                // Running off the bottom scrolls everything up by one row and
                // brings in a blank row at the bottom.
                if (shadow_cursor >= CELL_TOTAL) begin
                    for (int i = 0; i < CELL_TOTAL - COLUMNS; i++)
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    for (int i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
                        shadow_cells[i] = blank;
                    shadow_cursor = shadow_cursor - COLUMNS;
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < CELL_TOTAL; i++) shadow_cells[i] = blank;
                shadow_cursor = 0;
            end
            FUNC_READ: begin
                // Addresses past the last cell read back as zero.
                if (it.addr < CELL_TOTAL) r.data = shadow_cells[it.addr];
            end
            default: begin
            end
        endcase
        r.pos = shadow_cursor[POS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------
    term_item_t   input_backlog [$];
    term_result_t expected_reports [$];
    int           items_queued = 0;
    int           items_taken = 0;
    int           reports_seen = 0;
    int           errors = 0;

    // ------------------------------------------------------------------
    // Driver: offers the items of the backlog one at a time. After each
    // accepted item it draws a gap of idle cycles; now and then it switches
    // into a mode with no gaps at all so that back-to-back items occur.
    // ------------------------------------------------------------------
    term_item_t on_wire;
    int         send_gap = 0;
    bit         send_eager = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_reports.push_back(apply_to_screen(on_wire));
                items_taken++;
                if ($urandom_range(0, 31) == 0) send_eager = !send_eager;
                send_gap = send_eager ? 0 : $urandom_range(0, MAX_GAP);
            end
            // An item that is offered but not yet taken stays on the wires untouched.
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap--;
                end else if (input_backlog.size() != 0) begin
                    on_wire        = input_backlog.pop_front();
                    s_func         <= on_wire.func;
                    s_char_code    <= on_wire.ch;
                    s_cell_address <= on_wire.addr;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes each result, checks it against the oldest expectation
    // and then draws how long to hold off before taking the next one. Once,
    // it holds off for a long stretch so that the block backs up and stops
    // taking items while the driver keeps offering them.
    // ------------------------------------------------------------------
    term_result_t want;
    int           recv_stall = 0;
    bit           recv_eager = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: result with nothing expected: cursor %0d cell %h",
                                 $time, m_cursor_pos, m_cell_data);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_cursor_pos !== want.pos) begin
                        errors++;
                        if (errors <= REPORT_CAP)
                            $display("%0t: cursor_pos expected %0d actual %0d",
                                     $time, want.pos, m_cursor_pos);
                    end
                    if (m_cell_data !== want.data) begin
                        errors++;
                        if (errors <= REPORT_CAP)
                            $display("%0t: cell_data expected %h actual %h",
                                     $time, want.data, m_cell_data);
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_eager = !recv_eager;
                recv_stall = recv_eager ? 0 : $urandom_range(0, MAX_GAP);
                if (reports_seen == LONG_HOLD_AT) recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0) begin
                m_ready <= 1'b0;
                recv_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // A hung block ends the run here.
    longint cycles = 0;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                              input logic [CELL_ADDR_W-1:0] addr);
        term_item_t it;
        it.func = func;
        it.ch   = ch;
        it.addr = addr;
        input_backlog.push_back(it);
        items_queued++;
    endtask

    // Random items look like terminal traffic: mostly printable text broken up by
    // newlines, tabs and backspaces, with reads sprinkled in and the occasional
    // clear or unused operation. Newlines are frequent so the screen fills and
    // scrolls often. Fields that an operation ignores still carry random values.
    task automatic queue_random(input int count);
        term_item_t it;
        int         roll;
        for (int n = 0; n < count; n++) begin
            it.func = FUNC_PUT;
            it.ch   = CHAR_W'($urandom_range(32, 126));
            it.addr = CELL_ADDR_W'($urandom_range(0, 2047));
            roll    = $urandom_range(0, 999);
            if (roll < 5) begin
                it.func = FUNC_CLEAR;
            end else if (roll < 20) begin
                it.func = FUNC_UNUSED;
            end else if (roll < 160) begin
                it.func = FUNC_READ;
                // A few reads keep the full address range, so some land past the end.
                if (roll >= 30) it.addr = CELL_ADDR_W'($urandom_range(0, CELL_TOTAL - 1));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 22) it.ch = CH_NEWLINE;
                else if (roll < 32) it.ch = CH_BACKSPACE;
                else if (roll < 40) it.ch = CH_TAB;
                else if (roll < 52) it.ch = CHAR_W'($urandom_range(0, 255));
            end
            input_backlog.push_back(it);
        end
        items_queued += count;
    endtask

    // Waits until every queued item has been taken and every result has come
    // back, then waits out a further settling time before the caller goes on.
    task automatic wait_idle();
        do @(negedge aclk);
        while (items_taken != items_queued || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [COLOR_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {28'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        reg_write(REG_FG, fg);
        reg_write(REG_BG, bg);
        shadow_fg = fg;
        shadow_bg = bg;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence. The block runs a clearing pass after reset; the driver
    // simply waits for the input to open up.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening in the reset colors.
        queue_item(FUNC_PUT, CH_BACKSPACE, 11'd0);      // backspace at home does nothing
        queue_item(FUNC_READ, 8'd0, 11'd0);             // blank cell from the reset clear
        queue_item(FUNC_PUT, 8'h00, 11'd0);             // lowest character byte
        queue_item(FUNC_PUT, 8'hFF, 11'd2047);          // highest character byte
        queue_item(FUNC_PUT, 8'h41, 11'd0);
        queue_item(FUNC_PUT, CH_BACKSPACE, 11'd0);      // blanks the cell just written
        queue_item(FUNC_READ, 8'd0, 11'd2);
        queue_item(FUNC_READ, 8'd0, 11'd1);
        queue_item(FUNC_PUT, CH_TAB, 11'd0);            // from column 2 to 4
        queue_item(FUNC_PUT, CH_TAB, 11'd0);            // from a tab stop to the next
        queue_item(FUNC_PUT, CH_NEWLINE, 11'd0);
        queue_item(FUNC_PUT, 8'h5A, 11'd0);
        queue_item(FUNC_PUT, CH_NEWLINE, 11'd0);
        queue_item(FUNC_READ, 8'd0, CELL_ADDR_W'(CELL_TOTAL - 1));   // last cell
        queue_item(FUNC_READ, 8'd0, CELL_ADDR_W'(CELL_TOTAL));       // just past the end
        queue_item(FUNC_READ, 8'hFF, 11'd2047);                      // far past the end
        queue_item(FUNC_UNUSED, 8'hFF, 11'd2047);
        queue_item(FUNC_CLEAR, 8'hFF, 11'd2047);
        queue_item(FUNC_READ, 8'd0, 11'd80);
        queue_item(FUNC_PUT, 8'h78, 11'd0);
        queue_item(FUNC_READ, 8'd0, 11'd0);
        queue_random(240);
        wait_idle();

        // Both colors at their top value. The driver pauses halfway through
        // until the block has drained completely.
        set_colors(4'hF, 4'hF);
        queue_random(125);
        wait_idle();
        queue_random(125);
        wait_idle();

        // Both colors at zero.
        set_colors(4'h0, 4'h0);
        queue_random(250);
        wait_idle();

        // Some arbitrary pair of colors.
        set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
        queue_random(250);
        wait_idle();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
